[rtl/sbmq_pkg.sv]
package sbmq_pkg;

    // Default sizes
    localparam int QUEUE_COUNT_DEF = 8;
    localparam int SLOT_COUNT_DEF  = 256;

    // Fixed field widths
    localparam int DATA_W   = 32;
    localparam int QSEL_W   = 3;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

[rtl/sbmq_ram.sv]
module sbmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/shared_buffer_multi_queue.sv]
// Channel   Handshake                 Payload
// --------  ------------------------  ---------------------------------------
// command   start, busy (out)         operation, queue_select, push_value
// result    done (one-cycle strobe)   status, pop_value
//
// Each transaction passes three steps: accept (queue table read issued),
// look-up (slot link and data read issued), update (all writes, result
// registered). The result strobe rises the cycle after update, when busy is
// already low; busy is high in look-up and update, so the next transaction
// waits until update is over. The steps follow the chain queue table read ->
// slot memory read. Reset is asynchronous and immediate: queue table entries
// carry valid bits and the slot link memory is covered by a fill count, so
// no clearing pass is needed. The receiver cannot stall results.
module shared_buffer_multi_queue #(
    parameter int QUEUE_COUNT = sbmq_pkg::QUEUE_COUNT_DEF,
    parameter int SLOT_COUNT  = sbmq_pkg::SLOT_COUNT_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   operation,
    input  logic [sbmq_pkg::QSEL_W-1:0]            queue_select,
    input  logic signed [sbmq_pkg::DATA_W-1:0]     push_value,
    output logic                                   done,
    output logic [sbmq_pkg::STATUS_W-1:0]          status,
    output logic signed [sbmq_pkg::DATA_W-1:0]     pop_value
);

    localparam int DW = sbmq_pkg::DATA_W;
    // Pointer width holds every slot index plus the end marker (SLOT_COUNT)
    localparam int PW = $clog2(SLOT_COUNT + 1);
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam logic [PW-1:0] END_MARK = PW'(SLOT_COUNT);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]     state_reg, state_next;

    // Latched transaction
    logic           op_reg;
    logic [QW-1:0]  qidx_reg;
    logic           qok_reg;
    logic [DW-1:0]  val_reg;

    // Pointers captured in look-up
    logic [PW-1:0]  head_reg, tail_reg, slot_reg;
    logic           fresh_reg;

    // Free list and allocation state
    logic [PW-1:0]  free_head_reg, free_head_next;
    logic [PW-1:0]  fill_reg, fill_next;
    logic [QUEUE_COUNT-1:0] qvalid_reg, qvalid_next;

    // Result registers
    logic                           done_reg;
    logic [sbmq_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [DW-1:0]                  pop_reg, pop_next;

    // Memory ports
    logic             qt_rd_en, qt_wr_en;
    logic [QW-1:0]    qt_rd_addr;
    logic [2*PW-1:0]  qt_wr_data, qt_rd_data;
    logic             sl_rd_en;
    logic [PW-1:0]    sl_rd_ptr;
    logic             lk_wr_en;
    logic [SW-1:0]    lk_wr_addr;
    logic [PW-1:0]    lk_wr_data, lk_rd_data;
    logic             dt_wr_en;
    logic [DW-1:0]    dt_rd_data;

    logic             accept;
    logic [PW-1:0]    look_head, look_tail;
    logic [PW-1:0]    next_link;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign qt_rd_en   = accept;
    assign qt_rd_addr = QW'(queue_select);

    // Queue table: {head, tail}; an entry never written reads as empty
    sbmq_ram #(.WIDTH(2 * PW), .DEPTH(QUEUE_COUNT)) u_qtab (
        .clk     (clk),
        .wr_en   (qt_wr_en),
        .wr_addr (qidx_reg),
        .wr_data (qt_wr_data),
        .rd_en   (qt_rd_en),
        .rd_addr (qt_rd_addr),
        .rd_data (qt_rd_data)
    );

    // Slot link memory
    sbmq_ram #(.WIDTH(PW), .DEPTH(SLOT_COUNT)) u_link (
        .clk     (clk),
        .wr_en   (lk_wr_en),
        .wr_addr (lk_wr_addr),
        .wr_data (lk_wr_data),
        .rd_en   (sl_rd_en),
        .rd_addr (sl_rd_ptr[SW-1:0]),
        .rd_data (lk_rd_data)
    );

    // Slot data memory
    sbmq_ram #(.WIDTH(DW), .DEPTH(SLOT_COUNT)) u_data (
        .clk     (clk),
        .wr_en   (dt_wr_en),
        .wr_addr (slot_reg[SW-1:0]),
        .wr_data (val_reg),
        .rd_en   (sl_rd_en),
        .rd_addr (sl_rd_ptr[SW-1:0]),
        .rd_data (dt_rd_data)
    );

    // Look-up: resolve the queue entry and pick the slot to read
    always_comb
    begin
        if (qvalid_reg[qidx_reg])
        begin
            look_head = qt_rd_data[2*PW-1:PW];
            look_tail = qt_rd_data[PW-1:0];
        end
        else
        begin
            look_head = END_MARK;
            look_tail = END_MARK;
        end
        sl_rd_ptr = (op_reg == sbmq_pkg::OP_ENQ) ? free_head_reg : look_head;
        sl_rd_en  = (state_reg == S_LOOK) && qok_reg && (sl_rd_ptr != END_MARK);
    end

    // A slot at or above the fill count was never linked: it still points
    // to its successor as after reset
    assign next_link = fresh_reg ? (slot_reg + PW'(1)) : lk_rd_data;

    // Update: all memory writes and the result
    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        qvalid_next    = qvalid_reg;
        status_next    = status_reg;
        pop_next       = pop_reg;
        qt_wr_en       = 1'b0;
        qt_wr_data     = {head_reg, tail_reg};
        lk_wr_en       = 1'b0;
        lk_wr_addr     = tail_reg[SW-1:0];
        lk_wr_data     = slot_reg;
        dt_wr_en       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                state_next  = S_IDLE;
                status_next = sbmq_pkg::ST_EMPTY;
                pop_next    = '0;
                if (qok_reg)
                begin
                    if (op_reg == sbmq_pkg::OP_ENQ)
                    begin
                        if (slot_reg == END_MARK)
                        begin
                            status_next = sbmq_pkg::ST_FULL;
                        end
                        else
                        begin
                            status_next    = sbmq_pkg::ST_DONE;
                            free_head_next = next_link;
                            if (fresh_reg)
                            begin
                                fill_next = fill_reg + PW'(1);
                            end
                            qt_wr_en               = 1'b1;
                            qvalid_next[qidx_reg]  = 1'b1;
                            dt_wr_en               = 1'b1;
                            if (head_reg == END_MARK)
                            begin
                                qt_wr_data = {slot_reg, slot_reg};
                            end
                            else
                            begin
                                // Link the new slot after the old tail
                                qt_wr_data = {head_reg, slot_reg};
                                lk_wr_en   = 1'b1;
                                lk_wr_addr = tail_reg[SW-1:0];
                                lk_wr_data = slot_reg;
                            end
                        end
                    end
                    else
                    begin
                        if (head_reg != END_MARK)
                        begin
                            status_next = sbmq_pkg::ST_DONE;
                            pop_next    = dt_rd_data;
                            qt_wr_en    = 1'b1;
                            // Last element leaves: the queue becomes empty
                            if (head_reg == tail_reg)
                            begin
                                qt_wr_data = {END_MARK, END_MARK};
                            end
                            else
                            begin
                                qt_wr_data = {next_link, tail_reg};
                            end
                            // Push the freed slot onto the free list
                            lk_wr_en       = 1'b1;
                            lk_wr_addr     = head_reg[SW-1:0];
                            lk_wr_data     = free_head_reg;
                            free_head_next = head_reg;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            fill_reg      <= '0;
            qvalid_reg    <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            qvalid_reg    <= qvalid_next;
            done_reg      <= (state_reg == S_UPD);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            qidx_reg <= QW'(queue_select);
            qok_reg  <= (32'(queue_select) < 32'(QUEUE_COUNT));
            val_reg  <= DW'(push_value);
        end
        if (state_reg == S_LOOK)
        begin
            head_reg  <= look_head;
            tail_reg  <= look_tail;
            slot_reg  <= sl_rd_ptr;
            fresh_reg <= (sl_rd_ptr >= fill_reg);
        end
        status_reg <= status_next;
        pop_reg    <= pop_next;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign pop_value = signed'(pop_reg);

endmodule

[dv/queue_result_checker.sv]
module queue_result_checker
    import sbmq_pkg::*;
#(
    parameter int QUEUE_COUNT = QUEUE_COUNT_DEF,
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     operation,
    input  logic [QSEL_W-1:0]        queue_select,
    input  logic signed [DATA_W-1:0] push_value,
    input  logic                     done,
    input  logic [STATUS_W-1:0]      status,
    input  logic signed [DATA_W-1:0] pop_value,
    output int                       error_count,
    output int                       outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PTR_W  = $clog2(SLOT_COUNT + 1);
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOT_COUNT);

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] value;
    } queue_result_t;

    logic signed [DATA_W-1:0] slot_value [SLOT_COUNT];
    logic [PTR_W-1:0]         next_slot  [SLOT_COUNT];
    logic [PTR_W-1:0]         first_slot [QUEUE_COUNT];
    logic [PTR_W-1:0]         last_slot  [QUEUE_COUNT];
    logic [PTR_W-1:0]         free_slot;

    queue_result_t awaited_results [$];

    function automatic bit is_slot(logic [PTR_W-1:0] p);
        return p < NIL;
    endfunction

    // Apply one command to the shadow store and return what the block should answer.
    function automatic queue_result_t apply_queue_op(logic op, logic [QSEL_W-1:0] q,
                                                     logic signed [DATA_W-1:0] v);
        queue_result_t    r;
        logic [PTR_W-1:0] s;
        logic [PTR_W-1:0] t;
        r.status = ST_EMPTY;
        r.value  = '0;
        if (int'(q) < QUEUE_COUNT)
        begin
            if (op == OP_ENQ)
            begin
                s = free_slot;
                if (!is_slot(s))
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    t = last_slot[q];
                    free_slot = next_slot[s[SLOT_W-1:0]];
                    if (!is_slot(first_slot[q]) || !is_slot(t))
                        first_slot[q] = s;
                    else
                        next_slot[t[SLOT_W-1:0]] = s;
                    last_slot[q] = s;
                    next_slot[s[SLOT_W-1:0]] = NIL;
                    slot_value[s[SLOT_W-1:0]] = v;
                    r.status = ST_DONE;
                end
            end
            else
            begin
                s = first_slot[q];
                if (is_slot(s))
                begin
                    first_slot[q] = next_slot[s[SLOT_W-1:0]];
                    if (!is_slot(first_slot[q]))
                        last_slot[q] = NIL;
                    next_slot[s[SLOT_W-1:0]] = free_slot;
                    free_slot = s;
                    r.value = slot_value[s[SLOT_W-1:0]];
                    r.status = ST_DONE;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_value[i] = '0;
                next_slot[i]  = PTR_W'(i + 1);
            end
            for (int i = 0; i < QUEUE_COUNT; i++)
            begin
                first_slot[i] = NIL;
                last_slot[i]  = NIL;
            end
            free_slot = '0;
            awaited_results.delete();
            error_count = 0;
        end
        else
        begin
            if (start && !busy)
                awaited_results.push_back(apply_queue_op(operation, queue_select, push_value));
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    if (error_count < 10)
                        $display("%0t: result with nothing awaited: status %0d value %0d",
                                 $realtime, status, pop_value);
                    error_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status)
                    begin
                        if (error_count < 10)
                            $display("%0t: status mismatch: expected %0d actual %0d",
                                     $realtime, want.status, status);
                        error_count++;
                    end
                    if (pop_value !== want.value)
                    begin
                        if (error_count < 10)
                            $display("%0t: pop_value mismatch: expected %0d actual %0d",
                                     $realtime, want.value, pop_value);
                        error_count++;
                    end
                end
            end
        end
        outstanding = awaited_results.size();
    end

endmodule

[dv/shared_buffer_multi_queue_test.sv]
module shared_buffer_multi_queue_test;

    import sbmq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Random traffic is split into a fill stretch, a drain stretch and a mixed tail.
    localparam int FILL_ITEMS    = 275;
    localparam int DRAIN_ITEMS   = 190;
    localparam int MIXED_ITEMS   = 10;
    localparam int RANDOM_ITEMS  = FILL_ITEMS + DRAIN_ITEMS + MIXED_ITEMS;
    localparam int MAX_GAP       = 40;
    localparam int TAIL_CYCLES   = 12;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     operation;
    logic [QSEL_W-1:0]        queue_select;
    logic signed [DATA_W-1:0] push_value;
    logic                     done;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] pop_value;

    int error_count;
    int outstanding;

    // Free-running clock, 8 ns period.
    initial clk = 1'b0;
    always #4 clk = ~clk;

    shared_buffer_multi_queue #(
        .QUEUE_COUNT (QUEUE_COUNT_DEF),
        .SLOT_COUNT  (SLOT_COUNT_DEF)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .queue_select (queue_select),
        .push_value   (push_value),
        .done         (done),
        .status       (status),
        .pop_value    (pop_value)
    );

    queue_result_checker #(
        .QUEUE_COUNT (QUEUE_COUNT_DEF),
        .SLOT_COUNT  (SLOT_COUNT_DEF)
    ) checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .queue_select (queue_select),
        .push_value   (push_value),
        .done         (done),
        .status       (status),
        .pop_value    (pop_value),
        .error_count  (error_count),
        .outstanding  (outstanding)
    );

    // Draw an idle gap: each cycle the sender idles with the given percentage.
    function automatic int idle_gap(int pct);
        int n;
        n = 0;
        while (n < MAX_GAP && $urandom_range(99) < pct)
            n++;
        return n;
    endfunction

    // Issue one command transaction. Called right after a rising edge; returns
    // right after the edge at which the block accepted it. Start is only lowered
    // when a gap is wanted, so it never toggles twice within one time step.
    task automatic send_command(logic op, logic [QSEL_W-1:0] q,
                                logic signed [DATA_W-1:0] v, int gap);
        logic was_busy;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        operation    <= op;
        queue_select <= q;
        push_value   <= v;
        // Sample busy mid-cycle, where it is stable, to decide the next edge.
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end while (was_busy);
    endtask

    // Pick the operation for one random transaction: mostly the mix's main
    // direction, with a little noise of the other kind.
    function automatic logic pick_op(traffic_mix_t mix);
        case (mix)
            MIX_FILL:  return ($urandom_range(99) < 2)  ? OP_DEQ : OP_ENQ;
            MIX_DRAIN: return ($urandom_range(99) < 2)  ? OP_ENQ : OP_DEQ;
            default:   return ($urandom_range(99) < 50) ? OP_ENQ : OP_DEQ;
        endcase
    endfunction

    // Run limit: far beyond the slowest correct run (every item behind the
    // longest gap plus its pass through the block).
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        traffic_mix_t mix;
        int           idle_pct;

        // Hold every input at a known value while reset is asserted.
        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = OP_ENQ;
        queue_select = '0;
        push_value   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: dequeue from a queue that was never used.
        send_command(OP_DEQ, 3'd0, 32'sd0, 0);
        // Field extremes into the lowest and highest queues.
        send_command(OP_ENQ, 3'd0, 32'sh7fff_ffff, 0);
        send_command(OP_ENQ, 3'd0, 32'sh8000_0000, 0);
        send_command(OP_ENQ, 3'd7, 32'sh0000_0000, 0);
        send_command(OP_ENQ, 3'd7, 32'shffff_ffff, 0);
        // Drain queue 0: the second dequeue empties it and clears the tail,
        // the third is refused as empty.
        send_command(OP_DEQ, 3'd0, 32'sh1234_5678, 0);
        send_command(OP_DEQ, 3'd0, 32'sh0, 0);
        send_command(OP_DEQ, 3'd0, 32'sh0, 0);
        // Refill the emptied queue so the head is relinked, then drain it.
        send_command(OP_ENQ, 3'd0, 32'sh5555_5555, 0);
        send_command(OP_DEQ, 3'd0, 32'sh0, 0);
        // Touch every middle queue once each way; recycled slots come back out.
        for (int q = 1; q <= 6; q++)
        begin
            send_command(OP_ENQ, QSEL_W'(q), $signed(32'haaaa_0000 | q), 0);
            send_command(OP_DEQ, QSEL_W'(q), 32'sh0, 0);
        end
        send_command(OP_DEQ, 3'd7, 32'sh0, 0);
        send_command(OP_DEQ, 3'd7, 32'sh0, 0);
        send_command(OP_DEQ, 3'd7, 32'sh0, 0);

        // Random: fill past the store-full point, drain most of it, then mix.
        // Idle the sender 12% in the first third, 69% in the second, never in
        // the last.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i < FILL_ITEMS)
                mix = MIX_FILL;
            else if (i < FILL_ITEMS + DRAIN_ITEMS)
                mix = MIX_DRAIN;
            else
                mix = MIX_BALANCED;
            if (i < RANDOM_ITEMS / 3)
                idle_pct = 12;
            else if (i < 2 * RANDOM_ITEMS / 3)
                idle_pct = 69;
            else
                idle_pct = 0;
            send_command(pick_op(mix), QSEL_W'($urandom_range(7)), $signed($urandom),
                         idle_gap(idle_pct));
        end
        start <= 1'b0;

        // Wait for every awaited result, then keep clocking the block so that
        // any stray strobe shows.
        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
